>>> rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the multi-pattern byte scanner
// Item layouts, the command passed from front to back, memory entry
// layouts and the back-end state encoding.
// ----------------------------------------------------------------------------
package msc_pkg;

	// field widths fixed by the item layout
	localparam int STATE_W     = 10;
	localparam int SYM_W       = 8;
	localparam int HITS_W      = 11;
	localparam int OUT_TOTAL_W = 48;
	localparam int KIND_W      = 2;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_SCAN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOTO = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NODE = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [SYM_W-1:0]   symbol;
		logic [STATE_W-1:0] state_index;
		logic [STATE_W-1:0] target_state;
		logic               target_present;
		logic [HITS_W-1:0]  pattern_hits;
		logic               end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [HITS_W-1:0]      matches_here;
		logic [OUT_TOTAL_W-1:0] total_matches;
		logic [STATE_W-1:0]     state_now;
		logic                   text_done;
	} out_item_t;

	// operation carried by the command queue
	typedef enum logic [1:0] {
		OP_SCAN,
		OP_GOTO_WR,
		OP_NODE_WR
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [SYM_W-1:0]   symbol;
		logic [STATE_W-1:0] state_index;
		logic [STATE_W-1:0] target_state;
		logic               target_present;
		logic [HITS_W-1:0]  pattern_hits;
		logic               end_of_text;
	} cmd_t;

	// goto table entry
	typedef struct packed {
		logic               present;
		logic [STATE_W-1:0] target;
	} goto_entry_t;

	// per-state entry: failure link and hit count
	typedef struct packed {
		logic [STATE_W-1:0] fail;
		logic [HITS_W-1:0]  hits;
	} node_entry_t;

	// back-end walker states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_HITS
	} walk_fsm_t;

endpackage

>>> rtl/multi_pattern_byte_scanner.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_scanner: Aho-Corasick scanner over a byte stream
// Host-loaded goto, failure and hit tables; reports matches per byte and a
// saturating running total per text.
//
//   channel  dir   handshake            payload
//   item     in    push / full          msc_pkg::in_item_t
//   result   out   empty / pop          msc_pkg::out_item_t
//
// A table write completes in the idle state. A scanned byte passes the idle,
// look and hits states, repeating look for each failure link followed and
// when a failure loop is cut off and the walk restarts at the root; each
// step waits on the registered read of the goto and per-state memories.
// Items pass a 2-entry command queue; results wait in a 2-entry queue, and a
// scan starts only when that queue has room.
// Reset clears the scan state and total; the tables are not cleared.
// ----------------------------------------------------------------------------
module multi_pattern_byte_scanner #(
	parameter int STATE_COUNT = 1024,
	parameter int ALPHABET    = 256,
	parameter int TOTAL_BITS  = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  msc_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output msc_pkg::out_item_t result
);

	logic          cmd_valid;
	logic          cmd_pop;
	msc_pkg::cmd_t cmd;

	// intake and classification
	msc_front #(
		.STATE_COUNT(STATE_COUNT),
		.ALPHABET   (ALPHABET)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	// table writes and scanning
	msc_back #(
		.STATE_COUNT(STATE_COUNT),
		.ALPHABET   (ALPHABET),
		.TOTAL_BITS (TOTAL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

>>> rtl/msc_ram.sv
// ----------------------------------------------------------------------------
// msc_ram: generic single-port RAM
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module msc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/msc_fifo.sv
// ----------------------------------------------------------------------------
// msc_fifo: short register queue
// Push/full on the write side, pop/empty on the read side; head is shown
// while not empty.
// ----------------------------------------------------------------------------
module msc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rptr_q];

	// payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fifo count beyond depth");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("fifo count did not grow on push");

	a_cnt_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("fifo count did not shrink on pop");

endmodule

>>> rtl/msc_front.sv
// ----------------------------------------------------------------------------
// msc_front: item intake and classification
// Decodes the item kind, drops unused kinds and out-of-range writes, and
// queues the remaining commands for the back end.
// ----------------------------------------------------------------------------
module msc_front #(
	parameter int STATE_COUNT = 1024,
	parameter int ALPHABET    = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  msc_pkg::in_item_t item,
	output logic              full,
	output logic              cmd_valid,
	output msc_pkg::cmd_t     cmd,
	input  logic              cmd_pop
);

	localparam int CMD_W = $bits(msc_pkg::cmd_t);

	msc_pkg::cmd_t    dec;
	logic             keep;
	logic             idx_ok, sym_ok;
	logic             q_empty;
	logic [CMD_W-1:0] q_rdata;

	assign idx_ok = (32'(item.state_index) < STATE_COUNT);
	assign sym_ok = (32'(item.symbol) < ALPHABET);

	// classify the item
	always_comb begin
		dec.op             = msc_pkg::OP_SCAN;
		dec.symbol         = item.symbol;
		dec.state_index    = item.state_index;
		dec.target_state   = item.target_state;
		dec.target_present = item.target_present;
		dec.pattern_hits   = item.pattern_hits;
		dec.end_of_text    = item.end_of_text;
		keep               = 1'b0;
		unique case (item.kind)
			msc_pkg::KIND_SCAN: begin
				dec.op = msc_pkg::OP_SCAN;
				keep   = 1'b1;
			end
			msc_pkg::KIND_GOTO: begin
				dec.op = msc_pkg::OP_GOTO_WR;
				keep   = idx_ok && sym_ok;
			end
			msc_pkg::KIND_NODE: begin
				dec.op = msc_pkg::OP_NODE_WR;
				keep   = idx_ok;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	msc_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && keep),
		.wdata (dec),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd       = msc_pkg::cmd_t'(q_rdata);

endmodule

>>> rtl/msc_back.sv
// ----------------------------------------------------------------------------
// msc_back: table writes and failure-link walker
// Owns the goto and per-state memories, walks failure links for each
// scanned byte, keeps the running total and queues the results.
// ----------------------------------------------------------------------------
module msc_back #(
	parameter int STATE_COUNT = 1024,
	parameter int ALPHABET    = 256,
	parameter int TOTAL_BITS  = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  msc_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output msc_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	localparam int SW     = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
	localparam int AW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int G_DEP  = STATE_COUNT * (2 ** AW);
	localparam int G_AW   = $clog2(G_DEP);
	localparam int G_W    = $bits(msc_pkg::goto_entry_t);
	localparam int N_W    = $bits(msc_pkg::node_entry_t);
	localparam int STEP_W = $clog2(STATE_COUNT + 1);
	localparam int SUM_W  = TOTAL_BITS + 1;
	localparam int RES_W  = $bits(msc_pkg::out_item_t);

	msc_pkg::walk_fsm_t          state_q, state_d;
	logic [msc_pkg::STATE_W-1:0] cur_q, cur_d;
	logic [msc_pkg::STATE_W-1:0] walk_q, walk_d;
	logic [STEP_W-1:0]           steps_q, steps_d;
	logic [TOTAL_BITS-1:0]       total_q, total_d;
	logic                        g_oor_q, n_oor_q;

	logic [msc_pkg::STATE_W-1:0] rd_st;
	logic                        g_we, g_re, n_we, n_re;
	logic [G_AW-1:0]             g_addr;
	logic [SW-1:0]               n_addr;
	msc_pkg::goto_entry_t        g_wdata, g_rd;
	msc_pkg::node_entry_t        n_wdata, n_rd;
	logic [G_W-1:0]              g_rdata;
	logic [N_W-1:0]              n_rdata;

	logic                        g_hit;
	logic [msc_pkg::STATE_W-1:0] fail_st;
	logic [msc_pkg::HITS_W-1:0]  hits;
	logic [SUM_W-1:0]            sum;
	logic [TOTAL_BITS-1:0]       sat;

	msc_pkg::out_item_t          res;
	logic                        res_push, res_full;
	logic [RES_W-1:0]            res_rdata;

	// memory ports: writes come from the command, reads from the walker
	assign g_wdata.present = cmd.target_present;
	assign g_wdata.target  = cmd.target_present ? cmd.target_state : '0;
	assign n_wdata.fail    = cmd.target_state;
	assign n_wdata.hits    = cmd.pattern_hits;
	assign g_addr = g_we ? {SW'(cmd.state_index), AW'(cmd.symbol)}
	                     : {SW'(rd_st), AW'(cmd.symbol)};
	assign n_addr = n_we ? SW'(cmd.state_index) : SW'(rd_st);

	msc_ram #(
		.WIDTH(G_W),
		.DEPTH(G_DEP)
	) u_goto_ram (
		.clk  (clk),
		.we   (g_we),
		.re   (g_re),
		.addr (g_addr),
		.wdata(g_wdata),
		.rdata(g_rdata)
	);

	msc_ram #(
		.WIDTH(N_W),
		.DEPTH(STATE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (n_we),
		.re   (n_re),
		.addr (n_addr),
		.wdata(n_wdata),
		.rdata(n_rdata)
	);

	// read data, forced to the empty entry for out-of-range lookups
	assign g_rd    = msc_pkg::goto_entry_t'(g_rdata);
	assign n_rd    = msc_pkg::node_entry_t'(n_rdata);
	assign g_hit   = g_rd.present && !g_oor_q;
	assign fail_st = n_oor_q ? '0 : n_rd.fail;
	assign hits    = n_oor_q ? '0 : n_rd.hits;

	// saturating running total
	assign sum = {1'b0, total_q} + SUM_W'(hits);
	assign sat = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];

	assign res.matches_here  = hits;
	assign res.total_matches = msc_pkg::OUT_TOTAL_W'(sat);
	assign res.state_now     = walk_q;
	assign res.text_done     = cmd.end_of_text;

	// walker state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msc_pkg::S_IDLE;
			cur_q   <= '0;
			walk_q  <= '0;
			steps_q <= '0;
			total_q <= '0;
			g_oor_q <= 1'b0;
			n_oor_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			walk_q  <= walk_d;
			steps_q <= steps_d;
			total_q <= total_d;
			if (g_re) begin
				g_oor_q <= (32'(rd_st) >= STATE_COUNT) || (32'(cmd.symbol) >= ALPHABET);
			end
			if (n_re) begin
				n_oor_q <= (32'(rd_st) >= STATE_COUNT);
			end
		end
	end

	// walker next state and outputs
	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		walk_d   = walk_q;
		steps_d  = steps_q;
		total_d  = total_q;
		rd_st    = walk_q;
		g_we     = 1'b0;
		n_we     = 1'b0;
		g_re     = 1'b0;
		n_re     = 1'b0;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			msc_pkg::S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						msc_pkg::OP_GOTO_WR: begin
							g_we    = 1'b1;
							cmd_pop = 1'b1;
						end
						msc_pkg::OP_NODE_WR: begin
							n_we    = 1'b1;
							cmd_pop = 1'b1;
						end
						default: begin
							// scan: look up goto and failure link of the current state
							if (!res_full) begin
								rd_st   = cur_q;
								g_re    = 1'b1;
								n_re    = 1'b1;
								walk_d  = cur_q;
								steps_d = '0;
								state_d = msc_pkg::S_LOOK;
							end
						end
					endcase
				end
			end
			msc_pkg::S_LOOK: begin
				if (g_hit) begin
					walk_d  = g_rd.target;
					rd_st   = g_rd.target;
					n_re    = 1'b1;
					state_d = msc_pkg::S_HITS;
				end else if (walk_q == '0) begin
					rd_st   = '0;
					n_re    = 1'b1;
					state_d = msc_pkg::S_HITS;
				end else if (steps_q >= STEP_W'(STATE_COUNT)) begin
					// failure cycle guard: restart from the root
					walk_d = '0;
					rd_st  = '0;
					g_re   = 1'b1;
					n_re   = 1'b1;
				end else begin
					walk_d  = fail_st;
					rd_st   = fail_st;
					g_re    = 1'b1;
					n_re    = 1'b1;
					steps_d = steps_q + STEP_W'(1);
				end
			end
			msc_pkg::S_HITS: begin
				res_push = 1'b1;
				cmd_pop  = 1'b1;
				cur_d    = cmd.end_of_text ? '0 : walk_q;
				total_d  = cmd.end_of_text ? '0 : sat;
				state_d  = msc_pkg::S_IDLE;
			end
			default: begin
				state_d = msc_pkg::S_IDLE;
			end
		endcase
	end

	msc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign result = msc_pkg::out_item_t'(res_rdata);

	a_eot_root: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && cmd.end_of_text) |=> (cur_q == '0 && total_q == '0))
		else $error("scanner not back at root after end of text");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_W'(STATE_COUNT))
		else $error("failure walk beyond state count");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

endmodule

>>> test/tb_multi_pattern_byte_scanner.sv
// ----------------------------------------------------------------------------
// tb_multi_pattern_byte_scanner: self-checking bench for the byte scanner
// Loads small automata through goto and node writes, scans texts over each
// automaton's symbol set and checks every report against a local predictor.
// Both handshakes idle at random; the report side holds off for long
// stretches and the item side drains between automata.
// ----------------------------------------------------------------------------
module tb_multi_pattern_byte_scanner;
	import msc_pkg::*;

	localparam int          STATES         = 1024;
	localparam int          ITEM_TARGET    = 950;
	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          TAIL_CYCLES    = 40;
	localparam int          LONG_HOLD      = 150;
	localparam int          HOLD_AT_A      = 30;
	localparam int          HOLD_AT_B      = 300;
	localparam int          MAX_REPORTED   = 10;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam logic [OUT_TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		in_item_t   payload;
		logic [3:0] gap;
		logic       drain;
	} backlog_entry_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  item   = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	// stimulus and scoreboard state
	backlog_entry_t item_backlog[$];
	out_item_t      match_reports[$];
	int unsigned    stim_count   = 0;
	int unsigned    gap_burst    = 0;
	bit             drain_next   = 1'b0;
	int unsigned    mismatches   = 0;
	int unsigned    reports_seen = 0;
	logic           item_taken   = 1'b0;
	logic           report_taken = 1'b0;
	int unsigned    gap_left     = 0;
	bit             gap_loaded   = 1'b0;
	int unsigned    pop_wait     = 0;
	int unsigned    pop_burst    = 0;
	int unsigned    quiet_cycles = 0;

	// predictor copy of the automaton and the scan registers
	bit [HITS_W-1:0]      move_tab [0:STATES*256-1];
	bit [STATE_W-1:0]     fail_link [0:STATES-1];
	bit [HITS_W-1:0]      state_hits [0:STATES-1];
	logic [STATE_W-1:0]   walk_state = '0;
	logic [OUT_TOTAL_W-1:0] text_total = '0;

	multi_pattern_byte_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// predictor: apply one accepted item, queue the report a scan causes
	// ------------------------------------------------------------------
	task automatic absorb_item(input in_item_t it);
		logic [STATE_W-1:0] st;
		logic [HITS_W-1:0]  ent;
		logic [HITS_W-1:0]  here;
		int unsigned        steps;
		out_item_t          rep;
		case (it.kind)
			KIND_GOTO: begin
				move_tab[{it.state_index, it.symbol}] =
					it.target_present ? {1'b1, it.target_state} : '0;
			end
			KIND_NODE: begin
				fail_link[it.state_index]  = it.target_state;
				state_hits[it.state_index] = it.pattern_hits;
			end
			KIND_SCAN: begin
				// failure walk, bounded; a walk that runs out lands on the root
				st = walk_state;
				steps = 0;
				while (st != '0 && !move_tab[{st, it.symbol}][STATE_W] && steps < STATES) begin
					st = fail_link[st];
					steps++;
				end
				if (st != '0 && !move_tab[{st, it.symbol}][STATE_W])
					st = '0;
				ent = move_tab[{st, it.symbol}];
				if (ent[STATE_W])
					st = ent[STATE_W-1:0];
				here = state_hits[st];
				if (text_total > TOTAL_MAX - here)
					text_total = TOTAL_MAX;
				else
					text_total = text_total + here;
				rep.matches_here  = here;
				rep.total_matches = text_total;
				rep.state_now     = st;
				rep.text_done     = it.end_of_text;
				match_reports.push_back(rep);
				if (it.end_of_text) begin
					walk_state = '0;
					text_total = '0;
				end else begin
					walk_state = st;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_report(input out_item_t got);
		out_item_t want;
		if (match_reports.size() == 0) begin
			if (mismatches < MAX_REPORTED)
				$display("unexpected report: here=%0d total=%0d state=%0d done=%0b",
					got.matches_here, got.total_matches, got.state_now, got.text_done);
			mismatches++;
		end else begin
			want = match_reports.pop_front();
			if (got.matches_here !== want.matches_here || got.total_matches !== want.total_matches
					|| got.state_now !== want.state_now || got.text_done !== want.text_done) begin
				if (mismatches < MAX_REPORTED) begin
					$display("report mismatch: exp here=%0d total=%0d state=%0d done=%0b",
						want.matches_here, want.total_matches, want.state_now, want.text_done);
					$display("                 got here=%0d total=%0d state=%0d done=%0b",
						got.matches_here, got.total_matches, got.state_now, got.text_done);
				end
				mismatches++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------
	function automatic in_item_t random_item();
		bit [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	function automatic logic [HITS_W-1:0] pick_hits();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 11'd1024;
		if (r == 1)
			return HITS_W'($urandom_range(0, 1024));
		return HITS_W'($urandom_range(0, 3));
	endfunction

	task automatic queue_item(input in_item_t it);
		backlog_entry_t e;
		e.payload = it;
		e.drain   = drain_next;
		drain_next = 1'b0;
		// runs of back-to-back items between random gaps
		if (gap_burst > 0) begin
			gap_burst--;
			e.gap = '0;
		end else begin
			if ($urandom_range(0, 24) == 0)
				gap_burst = $urandom_range(10, 40);
			e.gap = 4'($urandom_range(0, 14));
		end
		item_backlog.push_back(e);
		if (it.kind != KIND_SPARE)
			stim_count++;
	endtask

	task automatic put_goto(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] sym,
			input logic pres, input logic [STATE_W-1:0] tgt);
		in_item_t it;
		it = random_item();
		it.kind           = KIND_GOTO;
		it.state_index    = st;
		it.symbol         = sym;
		it.target_present = pres;
		it.target_state   = tgt;
		queue_item(it);
	endtask

	task automatic put_node(input logic [STATE_W-1:0] st, input logic [STATE_W-1:0] fail,
			input logic [HITS_W-1:0] hits);
		in_item_t it;
		it = random_item();
		it.kind         = KIND_NODE;
		it.state_index  = st;
		it.target_state = fail;
		it.pattern_hits = hits;
		queue_item(it);
	endtask

	task automatic put_scan(input logic [SYM_W-1:0] sym, input logic last);
		in_item_t it;
		it = random_item();
		it.kind        = KIND_SCAN;
		it.symbol      = sym;
		it.end_of_text = last;
		queue_item(it);
	endtask

	// one automaton: noise writes, full tables for the used states and
	// symbols, then texts over those symbols; the last text always ends
	task automatic build_phase();
		logic [STATE_W-1:0] states[$];
		logic [SYM_W-1:0]   syms[$];
		logic [STATE_W-1:0] cand;
		logic [SYM_W-1:0]   scand;
		in_item_t           it;
		bit                 cyclic, dup, pres;
		int                 n, k, n_scans, text_left, i, j;
		drain_next = 1'b1;
		cyclic = ($urandom_range(0, 5) == 0);
		n = $urandom_range(2, 6);
		k = $urandom_range(1, 4);
		states.push_back('0);
		while (states.size() < n) begin
			cand = STATE_W'($urandom_range(1, STATES - 1));
			dup = 1'b0;
			foreach (states[m])
				if (states[m] == cand)
					dup = 1'b1;
			if (!dup)
				states.push_back(cand);
		end
		while (syms.size() < k) begin
			scand = SYM_W'($urandom_range(0, 255));
			dup = 1'b0;
			foreach (syms[m])
				if (syms[m] == scand)
					dup = 1'b1;
			if (!dup)
				syms.push_back(scand);
		end

		// noise: ignored kind and stray writes, overwritten below or never reached by the texts
		repeat ($urandom_range(0, 3)) begin
			it = random_item();
			it.kind = KIND_W'($urandom_range(1, 3));
			queue_item(it);
		end

		for (i = 0; i < n; i++) begin
			if (i == 0)
				put_node(states[0], STATE_W'($urandom_range(0, STATES - 1)), pick_hits());
			else if (cyclic)
				put_node(states[i], states[$urandom_range(0, n - 1)], pick_hits());
			else
				put_node(states[i], states[$urandom_range(0, i - 1)], pick_hits());
		end
		for (i = 0; i < n; i++)
			for (j = 0; j < k; j++) begin
				pres = ($urandom_range(0, 9) < (i == 0 ? 7 : 6));
				put_goto(states[i], syms[j], pres,
					pres ? states[$urandom_range(0, n - 1)] : 10'($urandom_range(0, STATES - 1)));
			end

		n_scans = $urandom_range(20, 60);
		text_left = $urandom_range(1, 15);
		for (i = 0; i < n_scans; i++) begin
			text_left--;
			put_scan(syms[$urandom_range(0, k - 1)], text_left == 0 || i == n_scans - 1);
			if (text_left == 0)
				text_left = $urandom_range(1, 15);
		end
	endtask

	// ------------------------------------------------------------------
	// item driver: one item per handshake, gaps drawn per item
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic next_push;
		backlog_entry_t head;
		if (arst_n) begin
			next_push = push;
			if (push && item_taken)
				next_push = 1'b0;
			if (!next_push && item_backlog.size() != 0) begin
				head = item_backlog[0];
				if (!gap_loaded) begin
					gap_left = 32'(head.gap);
					gap_loaded = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else if (!head.drain || match_reports.size() == 0) begin
					head = item_backlog.pop_front();
					item <= head.payload;
					gap_loaded = 1'b0;
					next_push = 1'b1;
				end
			end
			push <= next_push;
		end
	end

	// report side: random stalls, idle-free runs, two long hold-offs
	always @(negedge clk) begin
		logic next_pop;
		if (arst_n) begin
			next_pop = pop;
			if (pop && report_taken) begin
				next_pop = 1'b0;
				if (reports_seen == HOLD_AT_A || reports_seen == HOLD_AT_B) begin
					pop_wait = LONG_HOLD;
				end else if (pop_burst > 0) begin
					pop_burst--;
					pop_wait = 0;
				end else begin
					if ($urandom_range(0, 19) == 0)
						pop_burst = $urandom_range(10, 30);
					pop_wait = $urandom_range(0, 14);
				end
			end
			if (!next_pop) begin
				if (pop_wait != 0)
					pop_wait--;
				else
					next_pop = 1'b1;
			end
			pop <= next_pop;
		end
	end

	// ------------------------------------------------------------------
	// monitor: handshakes at the rising edge feed predictor and checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			item_taken   <= push && !full;
			report_taken <= pop && !empty;
			if (push && !full)
				absorb_item(item);
			if (pop && !empty) begin
				check_report(result);
				reports_seen++;
			end
		end
	end

	// watchdog: too long without any accepted item or report
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// directed automaton, random phases, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		in_item_t spare;
		// ignored kind, then root, deepest state with 1024 hits, and a
		// two-state failure loop
		spare = random_item();
		spare.kind = KIND_SPARE;
		queue_item(spare);
		put_node(10'd0, 10'h3FF, 11'd0);
		put_node(10'd1023, 10'd0, 11'd1024);
		put_node(10'd5, 10'd6, 11'd1);
		put_node(10'd6, 10'd5, 11'd2);
		put_goto(10'd0, 8'h00, 1'b1, 10'd1023);
		put_goto(10'd0, 8'hFF, 1'b1, 10'd5);
		put_goto(10'd0, 8'h7E, 1'b0, 10'h3FF);
		put_goto(10'd1023, 8'h00, 1'b1, 10'd1023);
		put_goto(10'd1023, 8'hFF, 1'b0, 10'h2AA);
		put_goto(10'd5, 8'h00, 1'b0, 10'h155);
		put_goto(10'd5, 8'hFF, 1'b1, 10'd5);
		put_goto(10'd6, 8'h00, 1'b0, 10'd0);
		put_goto(10'd6, 8'hFF, 1'b1, 10'd0);
		// root without goto, deep hits, failure to root, then the loop
		// that runs out and is forced to the root on the last byte
		put_scan(8'h7E, 1'b0);
		put_scan(8'h00, 1'b0);
		put_scan(8'h00, 1'b0);
		put_scan(8'hFF, 1'b0);
		put_scan(8'hFF, 1'b0);
		put_scan(8'h00, 1'b1);
		put_scan(8'hFF, 1'b1);
		put_scan(8'h00, 1'b0);
		put_scan(8'hFF, 1'b0);
		put_scan(8'hFF, 1'b1);

		while (stim_count < ITEM_TARGET)
			build_phase();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		while (item_backlog.size() != 0 || push || match_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
